// ----- rtl/svsi_pkg.sv -----
// Shared types and constants for the sorted voice slot table.
// No dependencies; imported by every other file of the block.
package svsi_pkg;

	localparam int SLOT_COUNT = 4;
	localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int DATA_W     = 24;
	localparam int POS_W      = 2;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

	typedef enum logic {
		CMD_INSERT = 1'b0,
		CMD_READ   = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [DATA_W-1:0] addr;
		logic [DATA_W-1:0] rem;
	} entry_t;

	typedef struct packed {
		logic             en;
		logic [IDX_W-1:0] idx;
		entry_t           data;
	} wr_req_t;

	typedef struct packed {
		cmd_t              command;
		logic [DATA_W-1:0] sample_address;
		logic [DATA_W-1:0] sample_length;
		logic [POS_W-1:0]  slot_index;
	} item_t;

	typedef struct packed {
		logic              accepted;
		logic              dropped;
		logic [POS_W-1:0]  position;
		logic [DATA_W-1:0] slot_address;
		logic [DATA_W-1:0] slot_remaining;
	} result_t;

endpackage

// ----- rtl/svsi_if.sv -----
// Valid/ready channel interfaces for command words and result words.
// Depends on svsi_pkg for field widths.
interface svsi_cmd_if import svsi_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              command;
	logic [DATA_W-1:0] sample_address;
	logic [DATA_W-1:0] sample_length;
	logic [POS_W-1:0]  slot_index;

	modport source (output valid, command, sample_address, sample_length, slot_index,
		input ready);
	modport sink (input valid, command, sample_address, sample_length, slot_index,
		output ready);
endinterface

interface svsi_rsp_if import svsi_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              accepted;
	logic              dropped;
	logic [POS_W-1:0]  position;
	logic [DATA_W-1:0] slot_address;
	logic [DATA_W-1:0] slot_remaining;

	modport source (output valid, accepted, dropped, position, slot_address, slot_remaining,
		input ready);
	modport sink (input valid, accepted, dropped, position, slot_address, slot_remaining,
		output ready);
endinterface

// ----- rtl/svsi_table.sv -----
// Slot table: SLOT_COUNT entries, one read and one write port, cleared at reset.
// Depends on svsi_pkg.
module svsi_table import svsi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [IDX_W-1:0] rd_idx,
	output entry_t           rd_data,
	input  wr_req_t          wr
);

	entry_t entry_q [SLOT_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				entry_q[i] <= '0;
			end
		end else if (wr.en) begin
			entry_q[wr.idx] <= wr.data;
		end
	end

	assign rd_data = entry_q[rd_idx];

endmodule

// ----- rtl/svsi_ctrl.sv -----
// Sequencer: walks the table one slot per cycle with a single length comparator,
// rippling displaced entries down. Depends on svsi_pkg.
module svsi_ctrl import svsi_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  item_t            item,
	output logic [IDX_W-1:0] rd_idx,
	input  entry_t           rd_data,
	output wr_req_t          wr,
	input  logic             res_free,
	output logic             res_valid,
	output result_t          res
);

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_READ  = 5'b00010,
		ST_WALK  = 5'b00100,
		ST_SHIFT = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t           state_q;
	logic [IDX_W-1:0] k_q;
	entry_t           carry_q;
	logic [POS_W-1:0] ridx_q;
	logic             oor_q;
	logic [POS_W-1:0] pos_q;
	result_t          res_q;

	logic geq;
	logic placing;
	logic last;
	logic old_free;

	assign geq      = rd_data.rem >= carry_q.rem;
	assign placing  = (state_q == ST_SHIFT) || ((state_q == ST_WALK) && !geq);
	assign last     = k_q == LAST_IDX;
	assign old_free = rd_data.rem == '0;

	assign item_ready = state_q == ST_IDLE;
	assign rd_idx     = k_q;
	assign wr.en      = placing;
	assign wr.idx     = k_q;
	assign wr.data    = carry_q;
	assign res_valid  = (state_q == ST_EMIT) && res_free;
	assign res        = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (item_valid) begin
						if (item.command == CMD_READ) begin
							k_q     <= IDX_W'(item.slot_index);
							state_q <= ST_READ;
						end else begin
							k_q     <= '0;
							state_q <= ST_WALK;
						end
					end
				end
				ST_READ: begin
					state_q <= ST_EMIT;
				end
				ST_WALK, ST_SHIFT: begin
					if (placing) begin
						if (old_free || last) begin
							state_q <= ST_EMIT;
						end else begin
							k_q     <= k_q + IDX_W'(1);
							state_q <= ST_SHIFT;
						end
					end else if (last) begin
						state_q <= ST_EMIT;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				ST_EMIT: begin
					if (res_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// datapath, no reset
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					carry_q.addr <= item.sample_address;
					carry_q.rem  <= item.sample_length;
					ridx_q       <= item.slot_index;
					oor_q        <= 32'(item.slot_index) >= SLOT_COUNT;
				end
			end
			ST_READ: begin
				res_q.accepted       <= 1'b0;
				res_q.dropped        <= 1'b0;
				res_q.position       <= ridx_q;
				res_q.slot_address   <= oor_q ? '0 : rd_data.addr;
				res_q.slot_remaining <= oor_q ? '0 : rd_data.rem;
			end
			ST_WALK, ST_SHIFT: begin
				res_q.slot_address   <= '0;
				res_q.slot_remaining <= '0;
				if (placing) begin
					carry_q <= rd_data;
					if (state_q == ST_WALK) begin
						pos_q <= POS_W'(k_q);
					end
					res_q.accepted <= 1'b1;
					res_q.dropped  <= !old_free && last;
					res_q.position <= (state_q == ST_WALK) ? POS_W'(k_q) : pos_q;
				end else begin
					res_q.accepted <= 1'b0;
					res_q.dropped  <= 1'b0;
					res_q.position <= '0;
				end
			end
			ST_EMIT: begin
			end
			default: begin
			end
		endcase
	end

endmodule

// ----- rtl/sorted_voice_slot_insert.sv -----
// Sorted voice slot table, top level: command channel, sequencer, table, result register.
// Depends on svsi_pkg, svsi_if, svsi_table and svsi_ctrl.
//
// req carries one command word: insert (sample_address, sample_length) or read (slot_index).
// rsp returns exactly one result word per command, in order.
// An insert walks the slots from slot 0, one slot per cycle through a single
// length comparator; once the insert point is found the displaced entries ripple
// down one slot per cycle until a free slot or the end of the table.
// req.ready is high only while the sequencer is idle, so one command is in work
// at a time. The result sits in an output register; if the register is occupied
// and rsp.ready is low the sequencer holds its result until the register frees,
// and no new command is taken meanwhile.
// Reset (arst_n low) clears every slot to free and empties the result register.
module sorted_voice_slot_insert import svsi_pkg::*; (
	input logic         clk,
	input logic         arst_n,
	svsi_cmd_if.sink    req,
	svsi_rsp_if.source  rsp
);

	item_t            item;
	logic [IDX_W-1:0] rd_idx;
	entry_t           rd_data;
	wr_req_t          wr;
	logic             res_free;
	logic             res_valid;
	result_t          res;
	logic             rsp_valid_q;
	result_t          rsp_q;

	assign item.command        = cmd_t'(req.command);
	assign item.sample_address = req.sample_address;
	assign item.sample_length  = req.sample_length;
	assign item.slot_index     = req.slot_index;

	svsi_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (req.valid),
		.item_ready (req.ready),
		.item       (item),
		.rd_idx     (rd_idx),
		.rd_data    (rd_data),
		.wr         (wr),
		.res_free   (res_free),
		.res_valid  (res_valid),
		.res        (res)
	);

	svsi_table u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_idx  (rd_idx),
		.rd_data (rd_data),
		.wr      (wr)
	);

	assign res_free = !rsp_valid_q || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_free) begin
			rsp_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			rsp_q <= res;
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.accepted       = rsp_q.accepted;
	assign rsp.dropped        = rsp_q.dropped;
	assign rsp.position       = rsp_q.position;
	assign rsp.slot_address   = rsp_q.slot_address;
	assign rsp.slot_remaining = rsp_q.slot_remaining;

`ifndef SYNTHESIS
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("command taken while sequencer busy");

	a_drop_needs_accept: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> (rsp.accepted || !rsp.dropped))
		else $error("drop flagged on a rejected or read result");

	a_insert_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.accepted |-> (rsp.slot_address == '0 && rsp.slot_remaining == '0))
		else $error("insert result carries slot data");

	a_write_only_insert: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> (wr.data.rem != '0 && !req.ready))
		else $error("table write of a free entry or while idle");
`endif

endmodule
